// ===== rtl/sab_pkg.sv =====
// shared types and constants of the suffix automaton builder
`default_nettype none
package sab_pkg;
    localparam int MAX_STATES = 8192;
    localparam int ALPHABET   = 26;
    localparam int MAX_TEXT   = 4096;
    localparam int STATE_W    = 13;
    localparam int SYM_W      = 5;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int TR_AW      = STATE_W + SYM_W;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_TRANS  = 2'd1;
    localparam logic [OP_W-1:0] OP_INFO   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    // transition read address
    localparam logic [1:0] TRA_ID_SYM = 2'd0;
    localparam logic [1:0] TRA_P_SYM  = 2'd1;
    localparam logic [1:0] TRA_Q_IDX  = 2'd2;
    // transition write address
    localparam logic [1:0] TWA_ROOT_IDX = 2'd0;
    localparam logic [1:0] TWA_NP_IDX   = 2'd1;
    localparam logic [1:0] TWA_NQ_IDX   = 2'd2;
    localparam logic [1:0] TWA_P_SYM    = 2'd3;
    // transition write data
    localparam logic [1:0] TWD_ZERO = 2'd0;
    localparam logic [1:0] TWD_NP   = 2'd1;
    localparam logic [1:0] TWD_NQ   = 2'd2;
    localparam logic [1:0] TWD_RD   = 2'd3;
    // state info read address
    localparam logic [2:0] RA_LAST = 3'd0;
    localparam logic [2:0] RA_ID   = 3'd1;
    localparam logic [2:0] RA_TR   = 3'd2;
    localparam logic [2:0] RA_P    = 3'd3;
    localparam logic [2:0] RA_Q    = 3'd4;
    localparam logic [2:0] RA_NP   = 3'd5;
    // state info write address
    localparam logic [1:0] WA_ROOT = 2'd0;
    localparam logic [1:0] WA_NP   = 2'd1;
    localparam logic [1:0] WA_NQ   = 2'd2;
    localparam logic [1:0] WA_Q    = 2'd3;
    // link write data
    localparam logic [2:0] LD_ZERO  = 3'd0;
    localparam logic [2:0] LD_ONE   = 3'd1;
    localparam logic [2:0] LD_Q     = 3'd2;
    localparam logic [2:0] LD_NQ    = 3'd3;
    localparam logic [2:0] LD_LINKQ = 3'd4;
    // q register source
    localparam logic [1:0] QS_ID = 2'd0;
    localparam logic [1:0] QS_TR = 2'd1;
    localparam logic [1:0] QS_NP = 2'd2;
    // result source
    localparam logic [1:0] FIN_ERR  = 2'd0;
    localparam logic [1:0] FIN_FULL = 2'd1;
    localparam logic [1:0] FIN_ZERO = 2'd2;
    localparam logic [1:0] FIN_RAM  = 2'd3;

    typedef struct packed {
        logic [1:0] tr_ra;
        logic       tr_we;
        logic [1:0] tr_wa;
        logic [1:0] tr_wd;
        logic [2:0] ra;
        logic [1:0] wa;
        logic       link_we;
        logic [2:0] link_d;
        logic       info_we;
        logic       len_zero;
        logic       end_d;
        logic       ld_in;
        logic       set_p_last;
        logic       p_from_link;
        logic       ld_lenp;
        logic       ld_q;
        logic [1:0] q_sel;
        logic       alloc_np;
        logic       alloc_nq;
        logic       ld_linkq;
        logic       idx_clr;
        logic       idx_inc;
        logic       set_cloned;
        logic       fin;
        logic [1:0] fin_sel;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sym_bad;
        logic            id_bad;
        logic            full;
        logic            tr_zero;
        logic            tr_eq_q;
        logic            p_zero;
        logic            len_match;
        logic            idx_last;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/sab_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/sab_dp.sv =====
// datapath: state stores, walk registers and result registers
`default_nettype none
module sab_dp import sab_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [SYM_W-1:0]   i_symbol,
    input  wire logic [STATE_W-1:0] i_state_id,
    output logic                    o_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [STATE_W-1:0]      o_result_state,
    output logic [STATE_W-1:0]      o_link_state,
    output logic [STATE_W-1:0]      o_longest_length,
    output logic                    o_end_mark,
    output logic                    o_cloned
);
    logic [OP_W-1:0]    r_op;
    logic [SYM_W-1:0]   r_sym, r_idx, n_idx;
    logic [STATE_W-1:0] r_id, r_p, r_np, r_q, r_nq, r_lenp, r_linkq, r_last, r_high;
    logic [STATE_W-1:0] n_p, n_q, n_last, n_high, n_np, n_nq;
    logic               r_cloned, n_cloned;

    logic [TR_AW-1:0]   tr_ra, tr_wa;
    logic [STATE_W-1:0] tr_wd, tr_rd;
    logic [STATE_W-1:0] ra, wa, link_wd, len_wd, link_rd, len_rd;
    logic               end_rd;
    logic [STATE_W-1:0] lenp1;
    logic [STATE_W:0]   high2;

    assign lenp1 = r_lenp + STATE_W'(1);
    assign high2 = {1'b0, r_high} + (STATE_W+1)'(2);

    always_comb begin
        case (i_cmd.tr_ra)
            TRA_ID_SYM: tr_ra = {r_id, r_sym};
            TRA_P_SYM:  tr_ra = {r_p, r_sym};
            TRA_Q_IDX:  tr_ra = {r_q, r_idx};
            default:    tr_ra = {r_p, r_sym};
        endcase
        case (i_cmd.tr_wa)
            TWA_ROOT_IDX: tr_wa = {STATE_W'(1), r_idx};
            TWA_NP_IDX:   tr_wa = {r_np, r_idx};
            TWA_NQ_IDX:   tr_wa = {r_nq, r_idx};
            default:      tr_wa = {r_p, r_sym};
        endcase
        case (i_cmd.tr_wd)
            TWD_ZERO: tr_wd = '0;
            TWD_NP:   tr_wd = r_np;
            TWD_NQ:   tr_wd = r_nq;
            default:  tr_wd = tr_rd;
        endcase
        case (i_cmd.ra)
            RA_LAST: ra = r_last;
            RA_ID:   ra = r_id;
            RA_TR:   ra = tr_rd;
            RA_P:    ra = r_p;
            RA_Q:    ra = r_q;
            default: ra = r_np;
        endcase
        case (i_cmd.wa)
            WA_ROOT: wa = STATE_W'(1);
            WA_NP:   wa = r_np;
            WA_NQ:   wa = r_nq;
            default: wa = r_q;
        endcase
        case (i_cmd.link_d)
            LD_ZERO: link_wd = '0;
            LD_ONE:  link_wd = STATE_W'(1);
            LD_Q:    link_wd = r_q;
            LD_NQ:   link_wd = r_nq;
            default: link_wd = r_linkq;
        endcase
        len_wd = i_cmd.len_zero ? '0 : lenp1;
    end

    sab_ram #(.WIDTH(STATE_W), .DEPTH(2**TR_AW)) u_trans (
        .i_clk(i_clk), .i_we(i_cmd.tr_we), .i_waddr(tr_wa), .i_wdata(tr_wd),
        .i_raddr(tr_ra), .o_rdata(tr_rd)
    );
    sab_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_link (
        .i_clk(i_clk), .i_we(i_cmd.link_we), .i_waddr(wa), .i_wdata(link_wd),
        .i_raddr(ra), .o_rdata(link_rd)
    );
    sab_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_len (
        .i_clk(i_clk), .i_we(i_cmd.info_we), .i_waddr(wa), .i_wdata(len_wd),
        .i_raddr(ra), .o_rdata(len_rd)
    );
    sab_ram #(.WIDTH(1), .DEPTH(MAX_STATES)) u_end (
        .i_clk(i_clk), .i_we(i_cmd.info_we), .i_waddr(wa), .i_wdata(i_cmd.end_d),
        .i_raddr(ra), .o_rdata(end_rd)
    );

    always_comb begin
        o_sts.op        = r_op;
        o_sts.sym_bad   = r_sym >= SYM_W'(ALPHABET);
        o_sts.id_bad    = (r_id == '0) || (r_id > r_high);
        o_sts.full      = (high2 >= (STATE_W+1)'(MAX_STATES)) ||
                          (len_rd >= STATE_W'(MAX_TEXT));
        o_sts.tr_zero   = tr_rd == '0;
        o_sts.tr_eq_q   = tr_rd == r_q;
        o_sts.p_zero    = r_p == '0;
        o_sts.len_match = lenp1 == len_rd;
        o_sts.idx_last  = r_idx == SYM_W'(ALPHABET - 1);
    end

    always_comb begin
        n_p      = r_p;
        n_q      = r_q;
        n_np     = r_np;
        n_nq     = r_nq;
        n_last   = r_last;
        n_high   = r_high;
        n_idx    = r_idx;
        n_cloned = r_cloned;
        if (i_cmd.set_p_last) begin
            n_p = r_last;
        end
        if (i_cmd.p_from_link) begin
            n_p = link_rd;
        end
        if (i_cmd.ld_q) begin
            case (i_cmd.q_sel)
                QS_ID:   n_q = r_id;
                QS_TR:   n_q = tr_rd;
                default: n_q = r_np;
            endcase
        end
        if (i_cmd.alloc_np) begin
            n_np   = r_high + STATE_W'(1);
            n_last = n_np;
            n_high = n_np;
        end
        if (i_cmd.alloc_nq) begin
            n_nq   = r_high + STATE_W'(1);
            n_high = n_nq;
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + SYM_W'(1);
        end
        if (i_cmd.ld_in) begin
            n_cloned = 1'b0;
        end else if (i_cmd.set_cloned) begin
            n_cloned = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= STATE_W'(1);
            r_high   <= STATE_W'(1);
            r_idx    <= '0;
            r_cloned <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_last   <= n_last;
            r_high   <= n_high;
            r_idx    <= n_idx;
            r_cloned <= n_cloned;
            o_valid  <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_op  <= i_opcode;
            r_sym <= i_symbol;
            r_id  <= i_state_id;
        end
        if (i_cmd.ld_lenp) begin
            r_lenp <= len_rd;
        end
        if (i_cmd.ld_linkq) begin
            r_linkq <= link_rd;
        end
        r_p  <= n_p;
        r_q  <= n_q;
        r_np <= n_np;
        r_nq <= n_nq;
        if (i_cmd.fin) begin
            case (i_cmd.fin_sel)
                FIN_ERR:  o_status <= ST_INVALID;
                FIN_FULL: o_status <= ST_FULL;
                default:  o_status <= ST_OK;
            endcase
            if (i_cmd.fin_sel == FIN_RAM) begin
                o_result_state   <= r_q;
                o_link_state     <= link_rd;
                o_longest_length <= len_rd;
                o_end_mark       <= end_rd;
                o_cloned         <= r_cloned;
            end else begin
                o_result_state   <= '0;
                o_link_state     <= '0;
                o_longest_length <= '0;
                o_end_mark       <= 1'b0;
                o_cloned         <= 1'b0;
            end
        end
    end

    a_last_le_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last <= r_high) else $error("last state beyond highest state");
    a_high_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high != '0) else $error("highest state is zero");
    a_high_step: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && !$stable(r_high))
        |-> r_high == $past(r_high) + STATE_W'(1))
        else $error("highest state moved by more than one");
endmodule
`default_nettype wire

// ===== rtl/sab_ctrl.sv =====
// controller state machine sequencing appends and queries
`default_nettype none
module sab_ctrl import sab_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [4:0] S_INIT_F   = 5'd0;
    localparam logic [4:0] S_INIT_ROW = 5'd1;
    localparam logic [4:0] S_IDLE     = 5'd2;
    localparam logic [4:0] S_DISP     = 5'd3;
    localparam logic [4:0] S_Q_T      = 5'd4;
    localparam logic [4:0] S_Q_OUT    = 5'd5;
    localparam logic [4:0] S_A_CHK    = 5'd6;
    localparam logic [4:0] S_A_CLR    = 5'd7;
    localparam logic [4:0] S_A_WRD    = 5'd8;
    localparam logic [4:0] S_A_WALK   = 5'd9;
    localparam logic [4:0] S_A_QRD    = 5'd10;
    localparam logic [4:0] S_A_QCMP   = 5'd11;
    localparam logic [4:0] S_A_CRD    = 5'd12;
    localparam logic [4:0] S_A_CWR    = 5'd13;
    localparam logic [4:0] S_A_L1     = 5'd14;
    localparam logic [4:0] S_A_L2     = 5'd15;
    localparam logic [4:0] S_A_L3     = 5'd16;
    localparam logic [4:0] S_A_RRD    = 5'd17;
    localparam logic [4:0] S_A_RED    = 5'd18;
    localparam logic [4:0] S_A_FIN    = 5'd19;
    localparam logic [4:0] S_A_OUT    = 5'd20;

    logic [4:0] r_state, n_state;

    assign o_busy = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.tr_ra = TRA_P_SYM;
        o_cmd.ra    = RA_P;
        case (r_state)
            S_INIT_F: begin
                o_cmd.wa       = WA_ROOT;
                o_cmd.link_we  = 1'b1;
                o_cmd.link_d   = LD_ZERO;
                o_cmd.info_we  = 1'b1;
                o_cmd.len_zero = 1'b1;
                o_cmd.idx_clr  = 1'b1;
                n_state = S_INIT_ROW;
            end
            S_INIT_ROW: begin
                o_cmd.tr_we   = 1'b1;
                o_cmd.tr_wa   = TWA_ROOT_IDX;
                o_cmd.tr_wd   = TWD_ZERO;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.ld_in = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_APPEND) begin
                    if (i_sts.sym_bad) begin
                        o_cmd.fin     = 1'b1;
                        o_cmd.fin_sel = FIN_ERR;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.ra         = RA_LAST;
                        o_cmd.set_p_last = 1'b1;
                        n_state = S_A_CHK;
                    end
                end else if (i_sts.id_bad || (i_sts.op != OP_TRANS && i_sts.op != OP_INFO)
                             || (i_sts.op == OP_TRANS && i_sts.sym_bad)) begin
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_sel = FIN_ERR;
                    n_state = S_IDLE;
                end else if (i_sts.op == OP_TRANS) begin
                    o_cmd.tr_ra = TRA_ID_SYM;
                    n_state = S_Q_T;
                end else begin
                    o_cmd.ra    = RA_ID;
                    o_cmd.ld_q  = 1'b1;
                    o_cmd.q_sel = QS_ID;
                    n_state = S_Q_OUT;
                end
            end
            S_Q_T: begin
                if (i_sts.tr_zero) begin
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_sel = FIN_ZERO;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ra    = RA_TR;
                    o_cmd.ld_q  = 1'b1;
                    o_cmd.q_sel = QS_TR;
                    n_state = S_Q_OUT;
                end
            end
            S_Q_OUT, S_A_OUT: begin
                o_cmd.fin     = 1'b1;
                o_cmd.fin_sel = FIN_RAM;
                n_state = S_IDLE;
            end
            S_A_CHK: begin
                if (i_sts.full) begin
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_sel = FIN_FULL;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ld_lenp  = 1'b1;
                    o_cmd.alloc_np = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_state = S_A_CLR;
                end
            end
            S_A_CLR: begin
                o_cmd.tr_we   = 1'b1;
                o_cmd.tr_wa   = TWA_NP_IDX;
                o_cmd.tr_wd   = TWD_ZERO;
                o_cmd.wa      = WA_NP;
                o_cmd.info_we = 1'b1;
                o_cmd.end_d   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_A_WRD;
                end
            end
            S_A_WRD: begin
                if (i_sts.p_zero) begin
                    o_cmd.wa      = WA_NP;
                    o_cmd.link_we = 1'b1;
                    o_cmd.link_d  = LD_ONE;
                    n_state = S_A_FIN;
                end else begin
                    n_state = S_A_WALK;
                end
            end
            S_A_WALK: begin
                if (i_sts.tr_zero) begin
                    o_cmd.tr_we       = 1'b1;
                    o_cmd.tr_wa       = TWA_P_SYM;
                    o_cmd.tr_wd       = TWD_NP;
                    o_cmd.p_from_link = 1'b1;
                    n_state = S_A_WRD;
                end else begin
                    o_cmd.ld_q    = 1'b1;
                    o_cmd.q_sel   = QS_TR;
                    o_cmd.ld_lenp = 1'b1;
                    n_state = S_A_QRD;
                end
            end
            S_A_QRD: begin
                o_cmd.ra = RA_Q;
                n_state = S_A_QCMP;
            end
            S_A_QCMP: begin
                if (i_sts.len_match) begin
                    o_cmd.wa      = WA_NP;
                    o_cmd.link_we = 1'b1;
                    o_cmd.link_d  = LD_Q;
                    n_state = S_A_FIN;
                end else begin
                    o_cmd.alloc_nq = 1'b1;
                    o_cmd.ld_linkq = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_state = S_A_CRD;
                end
            end
            S_A_CRD: begin
                o_cmd.tr_ra = TRA_Q_IDX;
                n_state = S_A_CWR;
            end
            S_A_CWR: begin
                o_cmd.tr_we = 1'b1;
                o_cmd.tr_wa = TWA_NQ_IDX;
                o_cmd.tr_wd = TWD_RD;
                if (i_sts.idx_last) begin
                    n_state = S_A_L1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_A_CRD;
                end
            end
            S_A_L1: begin
                o_cmd.wa      = WA_NQ;
                o_cmd.link_we = 1'b1;
                o_cmd.link_d  = LD_LINKQ;
                o_cmd.info_we = 1'b1;
                n_state = S_A_L2;
            end
            S_A_L2: begin
                o_cmd.wa      = WA_Q;
                o_cmd.link_we = 1'b1;
                o_cmd.link_d  = LD_NQ;
                n_state = S_A_L3;
            end
            S_A_L3: begin
                o_cmd.wa         = WA_NP;
                o_cmd.link_we    = 1'b1;
                o_cmd.link_d     = LD_NQ;
                o_cmd.set_cloned = 1'b1;
                n_state = S_A_RRD;
            end
            S_A_RRD: begin
                if (i_sts.p_zero) begin
                    n_state = S_A_FIN;
                end else begin
                    n_state = S_A_RED;
                end
            end
            S_A_RED: begin
                if (i_sts.tr_eq_q) begin
                    o_cmd.tr_we       = 1'b1;
                    o_cmd.tr_wa       = TWA_P_SYM;
                    o_cmd.tr_wd       = TWD_NQ;
                    o_cmd.p_from_link = 1'b1;
                    n_state = S_A_RRD;
                end else begin
                    n_state = S_A_FIN;
                end
            end
            S_A_FIN: begin
                o_cmd.ra    = RA_NP;
                o_cmd.ld_q  = 1'b1;
                o_cmd.q_sel = QS_NP;
                n_state = S_A_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_F;
        end else begin
            r_state <= n_state;
        end
    end

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> r_state == S_IDLE) else $error("result without return to idle");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_in |-> r_state == S_IDLE) else $error("item taken while busy");
    a_one_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.alloc_np && o_cmd.alloc_nq)) else $error("two states allocated at once");
endmodule
`default_nettype wire

// ===== rtl/suffix_automaton_builder_top.sv =====
// top level of the suffix automaton builder
//
// Builds a suffix automaton one symbol at a time. An item is taken when
// start is high and busy is low; opcode 0 appends a symbol, 1 reads a
// transition of a state, 2 reads the link, length and end mark of a state.
// Every item gives exactly one result, shown on the o_ ports for one cycle
// while o_valid is high; the receiver cannot stall, the result must be taken.
// Clearing the 26-entry transition row of a new state goes one entry per
// cycle through the single write port of the transition store; a clone has
// its row copied entry by entry, each entry read and then written. One item
// is in work at a time.
// After reset the block stays busy while it sets up the root state; the
// store is otherwise never swept, since states are handed out in order and
// every new state has its row written before use.
`default_nettype none
module suffix_automaton_builder_top import sab_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [SYM_W-1:0]   i_symbol,
    input  wire logic [STATE_W-1:0] i_state_id,
    output logic                    o_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [STATE_W-1:0]      o_result_state,
    output logic [STATE_W-1:0]      o_link_state,
    output logic [STATE_W-1:0]      o_longest_length,
    output logic                    o_end_mark,
    output logic                    o_cloned
);
    t_cmd cmd;
    t_sts sts;

    sab_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_sts(sts), .o_cmd(cmd)
    );

    sab_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_opcode(i_opcode), .i_symbol(i_symbol), .i_state_id(i_state_id),
        .o_valid(o_valid), .o_status(o_status), .o_result_state(o_result_state),
        .o_link_state(o_link_state), .o_longest_length(o_longest_length),
        .o_end_mark(o_end_mark), .o_cloned(o_cloned)
    );
endmodule
`default_nettype wire

// ===== test/sab_checker.sv =====
// checker of the suffix automaton builder: predicts every result and compares it
`timescale 1ns / 100ps
module sab_checker import sab_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [SYM_W-1:0]   i_symbol,
    input  wire logic [STATE_W-1:0] i_state_id,
    input  wire logic               o_valid,
    input  wire logic [STAT_W-1:0]  o_status,
    input  wire logic [STATE_W-1:0] o_result_state,
    input  wire logic [STATE_W-1:0] o_link_state,
    input  wire logic [STATE_W-1:0] o_longest_length,
    input  wire logic               o_end_mark,
    input  wire logic               o_cloned,
    output int                      o_errors,
    output int                      o_pending,
    output logic [STATE_W-1:0]      o_highest
);
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [STATE_W-1:0] target;
        logic [STATE_W-1:0] link;
        logic [STATE_W-1:0] len;
        logic               end_mark;
        logic               cloned;
    } t_res;

    logic [STATE_W-1:0] edges [MAX_STATES*ALPHABET];
    logic [STATE_W-1:0] links [MAX_STATES];
    logic [STATE_W-1:0] lens [MAX_STATES];
    logic               marks [MAX_STATES];
    int unsigned        last_st;
    int unsigned        top_st;
    t_res               outstanding [$];

    initial begin
        for (int i = 0; i < MAX_STATES*ALPHABET; i++) edges[i] = '0;
        for (int i = 0; i < MAX_STATES; i++) begin
            links[i] = '0;
            lens[i] = '0;
            marks[i] = 1'b0;
        end
        last_st = 1;
        top_st = 1;
        o_errors = 0;
        o_pending = 0;
        o_highest = 13'd1;
    end

    function automatic t_res describe(int unsigned st);
        t_res r;
        r = '0;
        r.target = st[STATE_W-1:0];
        if (st != 0) begin
            r.link = links[st];
            r.len = lens[st];
            r.end_mark = marks[st];
        end
        return r;
    endfunction

    task automatic grow(input int unsigned sym, output t_res r);
        int unsigned p, np, q, nq;
        logic split;
        p = last_st;
        split = 1'b0;
        r = '0;
        if (top_st + 2 >= MAX_STATES || lens[p] >= MAX_TEXT) begin
            r.status = ST_FULL;
            return;
        end
        top_st++;
        np = top_st;
        last_st = np;
        lens[np] = lens[p] + 1'b1;
        marks[np] = 1'b1;
        for (int k = 0; k < ALPHABET; k++) edges[np*ALPHABET+k] = '0;
        while (p != 0 && edges[p*ALPHABET+sym] == 0) begin
            edges[p*ALPHABET+sym] = np[STATE_W-1:0];
            p = links[p];
        end
        if (p == 0) begin
            links[np] = 13'd1;
        end else begin
            q = edges[p*ALPHABET+sym];
            if (int'(lens[p]) + 1 == int'(lens[q])) begin
                links[np] = q[STATE_W-1:0];
            end else begin
                top_st++;
                nq = top_st;
                lens[nq] = lens[p] + 1'b1;
                marks[nq] = 1'b0;
                for (int k = 0; k < ALPHABET; k++) edges[nq*ALPHABET+k] = edges[q*ALPHABET+k];
                links[nq] = links[q];
                links[q] = nq[STATE_W-1:0];
                links[np] = nq[STATE_W-1:0];
                while (p != 0 && edges[p*ALPHABET+sym] == q) begin
                    edges[p*ALPHABET+sym] = nq[STATE_W-1:0];
                    p = links[p];
                end
                split = 1'b1;
            end
        end
        r = describe(np);
        r.status = ST_OK;
        r.cloned = split;
    endtask

    task automatic predict_item(input logic [OP_W-1:0] op, input int unsigned sym,
                                input int unsigned id, output t_res r);
        r = '0;
        r.status = ST_INVALID;
        if (op == OP_APPEND) begin
            if (sym < ALPHABET) grow(sym, r);
        end else if ((op == OP_TRANS || op == OP_INFO) && id != 0 && id <= top_st) begin
            if (op == OP_INFO) begin
                r = describe(id);
                r.status = ST_OK;
            end else if (sym < ALPHABET) begin
                r = describe(edges[id*ALPHABET+sym]);
                r.status = ST_OK;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{o_status, o_result_state, o_link_state, o_longest_length,
                        o_end_mark, o_cloned};
                if (outstanding.size() == 0) begin
                    $error("result with no item waiting");
                    o_errors++;
                end else begin
                    want = outstanding.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_errors++;
                    end
                    if (got.target !== want.target) begin
                        $error("result_state: expected %0d, got %0d", want.target, got.target);
                        o_errors++;
                    end
                    if (got.link !== want.link) begin
                        $error("link_state: expected %0d, got %0d", want.link, got.link);
                        o_errors++;
                    end
                    if (got.len !== want.len) begin
                        $error("longest_length: expected %0d, got %0d", want.len, got.len);
                        o_errors++;
                    end
                    if (got.end_mark !== want.end_mark) begin
                        $error("end_mark: expected %0d, got %0d", want.end_mark, got.end_mark);
                        o_errors++;
                    end
                    if (got.cloned !== want.cloned) begin
                        $error("cloned: expected %0d, got %0d", want.cloned, got.cloned);
                        o_errors++;
                    end
                end
            end
            if (start && !busy) begin
                predict_item(i_opcode, i_symbol, i_state_id, want);
                outstanding.push_back(want);
            end
        end
        o_pending = outstanding.size();
        o_highest = top_st[STATE_W-1:0];
    end
endmodule

// ===== test/suffix_automaton_builder_top_test.sv =====
// testbench top of the suffix automaton builder: stimulus and verdict
`timescale 1ns / 100ps
module suffix_automaton_builder_top_test;
    import sab_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_opcode = OP_APPEND;
    logic [SYM_W-1:0]   i_symbol = '0;
    logic [STATE_W-1:0] i_state_id = '0;
    logic               o_valid;
    logic [STAT_W-1:0]  o_status;
    logic [STATE_W-1:0] o_result_state;
    logic [STATE_W-1:0] o_link_state;
    logic [STATE_W-1:0] o_longest_length;
    logic               o_end_mark;
    logic               o_cloned;
    int                 errors;
    int                 pending;
    logic [STATE_W-1:0] highest;
    int                 gap_pct;

    always #5 i_clk = ~i_clk;

    suffix_automaton_builder_top dut (.*);

    sab_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_symbol, .i_state_id,
        .o_valid, .o_status, .o_result_state, .o_link_state, .o_longest_length,
        .o_end_mark, .o_cloned, .o_errors(errors), .o_pending(pending),
        .o_highest(highest)
    );

    task automatic send_item(input logic [OP_W-1:0] op, input int unsigned sym,
                             input int unsigned id);
        @(negedge i_clk);
        if ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge i_clk);
        end
        i_opcode = op;
        i_symbol = sym[SYM_W-1:0];
        i_state_id = id[STATE_W-1:0];
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic random_item();
        int unsigned pick, sym, id;
        pick = $urandom_range(99);
        sym = ($urandom_range(3) == 0) ? $urandom_range(ALPHABET-1) : $urandom_range(2);
        if ($urandom_range(39) == 0) sym = $urandom_range(31, ALPHABET);
        id = ($urandom_range(9) == 0) ? $urandom_range(MAX_STATES-1) : $urandom_range(highest, 1);
        if (pick < 50) send_item(OP_APPEND, sym, id);
        else if (pick < 75) send_item(OP_TRANS, sym, id);
        else if (pick < 97) send_item(OP_INFO, sym, id);
        else send_item(2'd3, sym, id);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        gap_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(OP_INFO, 0, 1);
        send_item(OP_TRANS, 0, 1);
        send_item(OP_INFO, 0, 0);
        send_item(OP_INFO, 0, MAX_STATES-1);
        send_item(2'd3, 31, 1);
        send_item(OP_APPEND, 0, 0);
        send_item(OP_APPEND, 1, 0);
        send_item(OP_APPEND, 1, 0);
        send_item(OP_APPEND, 1, 0);
        send_item(OP_APPEND, 0, 0);
        send_item(OP_APPEND, ALPHABET-1, 0);
        send_item(OP_APPEND, 31, 0);
        send_item(OP_APPEND, ALPHABET, 0);
        send_item(OP_TRANS, 31, 1);
        send_item(OP_TRANS, 1, 1);
        send_item(OP_TRANS, 5, 2);
        send_item(OP_TRANS, 0, 0);
        send_item(OP_INFO, 0, 3);
        send_item(OP_INFO, 0, highest);
        send_item(OP_INFO, 0, highest + 1);
        drain();

        gap_pct = 28;
        repeat (320) random_item();
        drain();
        repeat ($urandom_range(20)) @(negedge i_clk);
        gap_pct = 70;
        repeat (310) random_item();
        gap_pct = 0;
        repeat (320) random_item();
        repeat (20) random_item();
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/sab_pkg.sv
rtl/sab_ram.sv
rtl/sab_dp.sv
rtl/sab_ctrl.sv
rtl/suffix_automaton_builder_top.sv
test/sab_checker.sv
test/suffix_automaton_builder_top_test.sv
